@@ rtl/bounded_ordered_list_engine_defines.svh @@
// Assertion macros used by the checker file of the ordered list engine.
// Holds no logic and depends on nothing.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH

// A property checked at every rising clock edge outside reset.
`define BOLE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A property that also holds during reset.
`define BOLE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/bole_pkg.sv @@
// Types, constants and codes of the ordered list engine.
// Used by the cell, the top level and the checker; depends on nothing.
`timescale 1ns / 1ps

package bole_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SORT_W   = $clog2(CAPACITY);
  localparam int VAL_W    = 32;
  localparam int OUT_CNT_W = 5;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4,
    OP_SORT       = 3'd5,
    OP_INSERT     = 3'd6,
    OP_REMOVE     = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_R,
    CELL_SHIFT_L,
    CELL_PUT_AT_COUNT,
    CELL_REMOVE,
    CELL_INSERT,
    CELL_SORT
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_SORT
  } state_t;

  typedef struct packed {
    cell_op_t                kind;
    logic signed [VAL_W-1:0] value;
    logic [CNT_W-1:0]        count;
    logic                    phase;
  } cell_cmd_t;

endpackage

@@ rtl/bole_cell.sv @@
// One cell of the list chain: holds one element and moves it to or from its neighbors.
// Depends on bole_pkg.
`timescale 1ns / 1ps

module bole_cell (
  input  logic                             clk,
  input  logic [bole_pkg::IDX_W-1:0]       idx,
  input  bole_pkg::cell_cmd_t              cmd,
  input  logic signed [bole_pkg::VAL_W-1:0] left_data,
  input  logic signed [bole_pkg::VAL_W-1:0] right_data,
  input  logic                             match_prev,
  input  logic                             ins_prev,
  input  logic                             swap_prev,
  output logic signed [bole_pkg::VAL_W-1:0] data,
  output logic                             match_out,
  output logic                             ins_out,
  output logic                             swap_out
);
  import bole_pkg::*;

  logic [CNT_W-1:0]        pos;
  logic                    held;
  logic                    at_count;
  logic                    ins_self;
  logic                    right_held;
  logic signed [VAL_W-1:0] data_next;

  assign pos        = CNT_W'(idx);
  assign held       = pos < cmd.count;
  assign at_count   = pos == cmd.count;
  assign right_held = (pos + CNT_W'(1)) < cmd.count;

  assign match_out = match_prev | (held && (data == cmd.value));

  // The new value belongs here if it fits between the left neighbor and this element,
  // or if this is the first free place.
  assign ins_self = at_count ||
                    (held && (cmd.value <= data) && ((idx == '0) || (left_data <= cmd.value)));
  assign ins_out  = ins_prev | ins_self;

  assign swap_out = (cmd.kind == CELL_SORT) && (idx[0] == cmd.phase) && right_held &&
                    (data > right_data);

  always_comb begin
    data_next = data;
    case (cmd.kind)
      CELL_SHIFT_R: data_next = (idx == '0) ? cmd.value : left_data;
      CELL_SHIFT_L: data_next = right_data;
      CELL_PUT_AT_COUNT: begin
        if (at_count) begin
          data_next = cmd.value;
        end
      end
      CELL_REMOVE: begin
        if (match_out) begin
          data_next = right_data;
        end
      end
      CELL_INSERT: begin
        if (ins_prev) begin
          data_next = left_data;
        end else if (ins_self) begin
          data_next = cmd.value;
        end
      end
      CELL_SORT: begin
        if (swap_out) begin
          data_next = right_data;
        end else if (swap_prev) begin
          data_next = left_data;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

@@ rtl/bounded_ordered_list_engine.sv @@
// Top level of the ordered list engine: control, element count, cell chain, result register.
// Depends on bole_pkg and bole_cell.
//
//   channel   direction  tdata                    tuser
//   s_*       in         value[31:0]              opcode[2:0]
//   m_*       out        count[4:0], zero pad     status[1:0]
//
// Every operation but sort is applied in the cycle its beat is accepted, and its result
// beat is valid in the next cycle. Sort runs CAPACITY odd-even transposition steps in the
// cell chain, and its result beat is registered at the end of the last step. A new beat is
// taken while idle and the result register is empty or being read. Reset (synchronous,
// active high) empties the list and the result register; element contents are not cleared.
`timescale 1ns / 1ps

module bounded_ordered_list_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value[31:0]
  input  logic [2:0]  s_tuser,   // opcode[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // count[4:0], zeros[7:5]
  output logic [1:0]  m_tuser    // status[1:0]
);
  import bole_pkg::*;

  state_t              state, state_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [SORT_W-1:0]   sort_cnt;
  logic                sort_last;
  logic                accept;
  logic                out_load;
  status_t             status_next;
  cell_cmd_t           cmd;
  cell_op_t            kind;
  opcode_t             op;
  logic                empty;
  logic                full;
  logic                found;

  logic signed [VAL_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]     match_chain;
  logic [CAPACITY-1:0]     ins_chain;
  logic [CAPACITY-1:0]     swap_chain;

  assign op        = opcode_t'(s_tuser);
  assign accept    = s_tvalid && s_tready;
  assign empty     = count == '0;
  assign full      = count == CNT_W'(CAPACITY);
  assign found     = match_chain[CAPACITY-1];
  assign sort_last = sort_cnt == SORT_W'(CAPACITY - 1);

  assign cmd.kind  = kind;
  assign cmd.value = $signed(s_tdata);
  assign cmd.count = count;
  assign cmd.phase = sort_cnt[0];

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      bole_cell u_cell (
        .clk        (clk),
        .idx        (IDX_W'(g)),
        .cmd        (cmd),
        .left_data  ((g == 0) ? '0 : cell_data[(g == 0) ? 0 : g - 1]),
        .right_data ((g == CAPACITY - 1) ? '0 : cell_data[(g == CAPACITY - 1) ? g : g + 1]),
        .match_prev ((g == 0) ? 1'b0 : match_chain[(g == 0) ? 0 : g - 1]),
        .ins_prev   ((g == 0) ? 1'b0 : ins_chain[(g == 0) ? 0 : g - 1]),
        .swap_prev  ((g == 0) ? 1'b0 : swap_chain[(g == 0) ? 0 : g - 1]),
        .data       (cell_data[g]),
        .match_out  (match_chain[g]),
        .ins_out    (ins_chain[g]),
        .swap_out   (swap_chain[g])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (op == OP_SORT)) begin
          state_next = ST_SORT;
        end
      end
      ST_SORT: begin
        if (sort_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    kind        = CELL_HOLD;
    status_next = STAT_OK;
    count_next  = count;
    out_load    = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = !m_tvalid || m_tready;
        if (accept) begin
          out_load = op != OP_SORT;
          case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
              if (full) begin
                status_next = STAT_FULL;
              end else begin
                count_next = count + CNT_W'(1);
                case (op)
                  OP_PUSH_FRONT: kind = CELL_SHIFT_R;
                  OP_PUSH_BACK:  kind = CELL_PUT_AT_COUNT;
                  default:       kind = CELL_INSERT;
                endcase
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (empty) begin
                status_next = STAT_EMPTY;
              end else begin
                count_next = count - CNT_W'(1);
                kind       = (op == OP_POP_FRONT) ? CELL_SHIFT_L : CELL_HOLD;
              end
            end
            OP_SEARCH: status_next = found ? STAT_OK : STAT_NOTFOUND;
            OP_REMOVE: begin
              if (empty) begin
                status_next = STAT_EMPTY;
              end else if (found) begin
                count_next = count - CNT_W'(1);
                kind       = CELL_REMOVE;
              end else begin
                status_next = STAT_NOTFOUND;
              end
            end
            default: kind = CELL_HOLD;
          endcase
        end
      end
      ST_SORT: begin
        kind     = CELL_SORT;
        out_load = sort_last;
      end
      default: kind = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      sort_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == ST_SORT) begin
        sort_cnt <= sort_cnt + SORT_W'(1);
      end else begin
        sort_cnt <= '0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= 8'(OUT_CNT_W'(count_next));
      m_tuser <= status_next;
    end
  end

endmodule

@@ rtl/bole_checker.sv @@
// Port-level checks of the ordered list engine, bound to its top level.
// Depends on bole_pkg and bounded_ordered_list_engine_defines.svh.
`timescale 1ns / 1ps
`include "bounded_ordered_list_engine_defines.svh"

module bole_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [2:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic [1:0]  m_tuser
);
  import bole_pkg::*;

  `BOLE_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")
  `BOLE_ASSERT(a_full_count, clk, rst, m_tvalid && (m_tuser == STAT_FULL) |-> (m_tdata[4:0] == OUT_CNT_W'(CAPACITY)), "full status with a count below capacity")
  `BOLE_ASSERT(a_empty_count, clk, rst, m_tvalid && (m_tuser == STAT_EMPTY) |-> (m_tdata[4:0] == 5'd0), "empty status with a nonzero count")
  `BOLE_ASSERT(a_sort_busy, clk, rst, s_tvalid && s_tready && (s_tuser == OP_SORT) |=> !s_tready, "input taken while a sort runs")
  `BOLE_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !m_tvalid, "result beat valid right after reset")

endmodule

bind bounded_ordered_list_engine bole_checker u_bole_checker (.*);
